// File: rtl/core/itum_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itum_pkg: shared types and constants for the timestamp-to-millis unit
// Field layout, status codes, conversion constants and the record that
// travels from the character parser to the conversion pipeline.
// ----------------------------------------------------------------------------
package itum_pkg;

    // text layout
    localparam int FIELDS    = 6;
    localparam int FLD_W     = 14;
    localparam int FIELD_MAX = 9999;
    localparam int MIN_LEN   = 19;
    localparam int SEP_POS   = 10;
    localparam int POS_MAX   = 31;

    // start offset of each decimal field: year, month, day, hour, minute, second
    localparam logic [FIELDS-1:0][4:0] FIELD_OFS = {5'd17, 5'd14, 5'd11, 5'd8, 5'd5, 5'd0};

    // field slots
    localparam int F_YEAR = 0;
    localparam int F_MON  = 1;
    localparam int F_DAY  = 2;
    localparam int F_HOUR = 3;
    localparam int F_MIN  = 4;
    localparam int F_SEC  = 5;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_T     = 8'h54;

    // parse status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_BADSEP = 2'd2;

    // conversion constants
    localparam int EPOCH_DAYS   = 719561;
    localparam int SECS_PER_DAY = 86400;
    localparam int MS_PER_SEC   = 1000;
    localparam int SECS_PER_HR  = 3600;
    localparam int SECS_PER_MIN = 60;

    // reciprocals: x/100 = (x*5243)>>19 for x < 43699,
    // (3x)/5 = (x*157287)>>18 for 3x < 65536
    localparam int RECIP100    = 5243;
    localparam int RECIP100_SH = 19;
    localparam int RECIP3D5    = 157287;
    localparam int RECIP3D5_SH = 18;

    // parser-to-converter queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [FIELDS-1:0][FLD_W-1:0] fld;
        logic [1:0]                   status;
    } t_rec;

endpackage

// File: rtl/core/itum_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itum_front: character parser
// Takes one character per item, accumulates the six decimal fields and the
// separator, and on the last character emits one record with a status.
// ----------------------------------------------------------------------------
module itum_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_char_byte,
    input  logic              i_last_char,
    output logic              o_wr,
    output itum_pkg::t_rec    o_rec
);

    // one digit step with saturation at the field maximum
    function automatic logic [itum_pkg::FLD_W-1:0] f_acc_step(
        input logic [itum_pkg::FLD_W-1:0] a,
        input logic [3:0]                 d
    );
        logic [16:0] v;
        v = 17'(a) * 17'd10 + 17'(d);
        return (v > 17'(itum_pkg::FIELD_MAX)) ? itum_pkg::FLD_W'(itum_pkg::FIELD_MAX)
                                              : v[itum_pkg::FLD_W-1:0];
    endfunction

    logic [4:0]                                     r_pos, n_pos;
    logic                                           r_ended, n_ended;
    logic [itum_pkg::FIELDS-1:0][itum_pkg::FLD_W-1:0] r_acc, n_acc;
    logic [itum_pkg::FIELDS-1:0]                    r_rd, n_rd;
    logic [7:0]                                     r_sep, n_sep;

    logic       digit;
    logic [3:0] dv;

    assign digit = (i_char_byte >= itum_pkg::CH_ZERO) && (i_char_byte <= itum_pkg::CH_NINE);
    assign dv    = digit ? 4'(i_char_byte - itum_pkg::CH_ZERO) : 4'd0;

    // next parser state for the item on the port
    always_comb begin
        n_pos   = r_pos;
        n_ended = r_ended;
        n_acc   = r_acc;
        n_rd    = r_rd;
        n_sep   = r_sep;
        if (i_take && !r_ended) begin
            if (i_char_byte == itum_pkg::CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                for (int i = 0; i < itum_pkg::FIELDS; i++) begin
                    if (r_pos == itum_pkg::FIELD_OFS[i]) begin
                        n_acc[i] = itum_pkg::FLD_W'(dv);
                        n_rd[i]  = digit;
                    end else if (r_rd[i]) begin
                        if (digit) begin
                            n_acc[i] = f_acc_step(r_acc[i], dv);
                        end else begin
                            n_rd[i] = 1'b0;
                        end
                    end
                end
                if (r_pos == 5'(itum_pkg::SEP_POS)) begin
                    n_sep = i_char_byte;
                end
                if (r_pos < 5'(itum_pkg::POS_MAX)) begin
                    n_pos = r_pos + 5'd1;
                end
            end
        end
    end

    // record for the converter, built from the updated state
    always_comb begin
        o_rec.fld = n_acc;
        if (n_pos < 5'(itum_pkg::MIN_LEN)) begin
            o_rec.status = itum_pkg::ST_SHORT;
        end else if (n_sep != itum_pkg::CH_SPACE && n_sep != itum_pkg::CH_T) begin
            o_rec.status = itum_pkg::ST_BADSEP;
        end else begin
            o_rec.status = itum_pkg::ST_OK;
        end
    end

    assign o_wr = i_take && i_last_char;

    // state registers, cleared after each finished string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_wr) begin
            r_pos   <= '0;
            r_ended <= 1'b0;
            r_acc   <= '0;
            r_rd    <= '0;
            r_sep   <= '0;
        end else begin
            r_pos   <= n_pos;
            r_ended <= n_ended;
            r_acc   <= n_acc;
            r_rd    <= n_rd;
            r_sep   <= n_sep;
        end
    end

endmodule

// File: rtl/core/itum_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itum_queue: short record queue
// Holds parsed records between the parser and the conversion pipeline so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module itum_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  itum_pkg::t_rec    i_wdata,
    output logic              o_full,
    input  logic              i_rd,
    output logic              o_valid,
    output itum_pkg::t_rec    o_rdata
);

    localparam int AW = (itum_pkg::QUEUE_DEPTH > 1) ? $clog2(itum_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(itum_pkg::QUEUE_DEPTH + 1);

    itum_pkg::t_rec r_mem [itum_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(itum_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];

    // pointer advance with wrap
    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(itum_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= f_next(r_wptr);
            end
            if (i_rd) begin
                r_rptr <= f_next(r_rptr);
            end
            r_cnt <= r_cnt + CW'(i_wr) - CW'(i_rd);
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && o_full))
        else $error("write into full record queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_rd && !o_valid))
        else $error("read from empty record queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(itum_pkg::QUEUE_DEPTH))
        else $error("record queue count out of range");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr && !i_rd) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("record queue count did not follow a write");

endmodule

// File: rtl/core/itum_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itum_back: days-from-civil conversion pipeline
// Six stages from a parsed record to Unix milliseconds; the last stage is
// the result register. All stages move together when the result register
// is free or being taken.
// ----------------------------------------------------------------------------
module itum_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  itum_pkg::t_rec    i_rec,
    output logic              o_rd,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [48:0]       o_unix_millis,
    output logic [1:0]        o_parse_status
);

    localparam int FW = itum_pkg::FLD_W;

    logic       adv;
    logic [5:0] r_vld;

    // stage 1: month shift
    logic signed [FW:0] r_y1;
    logic [FW-1:0]      r_yp1, r_m1, r_d1, r_h1, r_mi1, r_s1;
    logic [1:0]         r_st1;
    // stage 2: constant products
    logic [23:0]        r_y365;
    logic [26:0]        r_p100;
    logic [24:0]        r_p400;
    logic [11:0]        r_q4;
    logic [18:0]        r_m30;
    logic [30:0]        r_p5;
    logic [FW-1:0]      r_d2;
    logic [25:0]        r_tod2;
    logic [1:0]         r_st2;
    // stage 3: day count
    logic [23:0]        r_days;
    logic [25:0]        r_tod3;
    logic [1:0]         r_st3;
    // stage 4: seconds of the day count
    logic [40:0]        r_sd;
    logic [25:0]        r_tod4;
    logic [1:0]         r_st4;
    // stage 5: total seconds
    logic [40:0]        r_t;
    logic [1:0]         r_st5;
    // stage 6: result register
    logic [48:0]        r_ms;
    logic [1:0]         r_st6;

    logic [FW-1:0]      y_in, m_in;
    logic signed [FW:0] n_y1;
    logic [FW-1:0]      n_m1;
    logic [23:0]        n_days;
    logic [40:0]        n_t;
    logic [50:0]        n_ms;

    assign adv     = !r_vld[5] || i_pop;
    assign o_rd    = adv && i_valid;
    assign o_valid = r_vld[5];
    assign o_unix_millis  = r_ms;
    assign o_parse_status = r_st6;

    // months 1 and 2 count as 13 and 14 of the previous year
    assign y_in = i_rec.fld[itum_pkg::F_YEAR];
    assign m_in = i_rec.fld[itum_pkg::F_MON];
    always_comb begin
        if (m_in <= FW'(2)) begin
            n_y1 = $signed({1'b0, y_in}) - (FW+1)'(1);
            n_m1 = m_in + FW'(12);
        end else begin
            n_y1 = $signed({1'b0, y_in});
            n_m1 = m_in;
        end
    end

    // day count, two's complement modulo 2^24
    assign n_days = r_y365 + 24'(r_q4)
                  - 24'(r_p100[26:itum_pkg::RECIP100_SH])
                  + 24'(r_p400[24:itum_pkg::RECIP100_SH])
                  + 24'(r_m30) + 24'(r_p5[30:itum_pkg::RECIP3D5_SH]) + 24'(r_d2)
                  - 24'(itum_pkg::EPOCH_DAYS);

    // total seconds, minus one second reads as zero
    always_comb begin
        n_t = r_sd + 41'(r_tod4);
        if (n_t == '1) begin
            n_t = '0;
        end
    end

    assign n_ms = 51'($signed(r_t)) * 51'(itum_pkg::MS_PER_SEC);

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (adv) begin
            // stage 1
            r_y1  <= n_y1;
            r_yp1 <= n_y1[FW] ? '0 : n_y1[FW-1:0];
            r_m1  <= n_m1;
            r_d1  <= i_rec.fld[itum_pkg::F_DAY];
            r_h1  <= i_rec.fld[itum_pkg::F_HOUR];
            r_mi1 <= i_rec.fld[itum_pkg::F_MIN];
            r_s1  <= i_rec.fld[itum_pkg::F_SEC];
            r_st1 <= i_rec.status;
            // stage 2
            r_y365 <= 24'(r_y1) * 24'd365;
            r_p100 <= 27'(r_yp1) * 27'(itum_pkg::RECIP100);
            r_p400 <= 25'(r_yp1[FW-1:2]) * 25'(itum_pkg::RECIP100);
            r_q4   <= r_yp1[FW-1:2];
            r_m30  <= 19'(r_m1) * 19'd30;
            r_p5   <= 31'(15'(r_m1) + 15'd1) * 31'(itum_pkg::RECIP3D5);
            r_d2   <= r_d1;
            r_tod2 <= 26'(r_h1) * 26'(itum_pkg::SECS_PER_HR)
                    + 26'(r_mi1) * 26'(itum_pkg::SECS_PER_MIN) + 26'(r_s1);
            r_st2  <= r_st1;
            // stage 3
            r_days <= n_days;
            r_tod3 <= r_tod2;
            r_st3  <= r_st2;
            // stage 4
            r_sd   <= 41'($signed(r_days)) * 41'(itum_pkg::SECS_PER_DAY);
            r_tod4 <= r_tod3;
            r_st4  <= r_st3;
            // stage 5
            r_t    <= n_t;
            r_st5  <= r_st4;
            // stage 6
            r_ms   <= (r_st5 == itum_pkg::ST_OK) ? n_ms[48:0] : '0;
            r_st6  <= r_st5;
        end
    end

endmodule

// File: rtl/core/iso_timestamp_to_unix_millis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso_timestamp_to_unix_millis_unit: text timestamp to Unix milliseconds
// Parses "YYYY-MM-DD?HH:MM:SS" one character per item and gives one result
// item, milliseconds since 1970-01-01 plus a status, per string.
//
//  Channel  | Handshake           | Payload
//  ---------+---------------------+--------------------------------------
//  input    | push / full         | i_char_byte[7:0], i_last_char
//  result   | empty / pop         | o_unix_millis[48:0], o_parse_status[1:0]
//
// One character is taken every cycle while full is low; the parser holds no stall of its own.
// A string's record enters the queue at the edge that accepts its last
// character, then moves into the first conversion stage and on through the
// pipeline to the sixth stage, the result register.
// full rises only when the two-entry record queue is full, i.e. when the
// result side has stalled long enough to back up the conversion pipeline.
// Reset (synchronous, active low) clears the parser, the queue and all
// stage valids; no clearing pass is needed.
// ----------------------------------------------------------------------------
module iso_timestamp_to_unix_millis_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_byte,
    input  logic        i_last_char,
    output logic        empty,
    input  logic        pop,
    output logic [48:0] o_unix_millis,
    output logic [1:0]  o_parse_status
);

    logic           take;
    logic           q_wr, q_rd, q_valid, b_valid;
    itum_pkg::t_rec q_wdata, q_rdata;

    assign take  = push && !full;
    assign empty = !b_valid;

    // character parser
    itum_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_char_byte (i_char_byte),
        .i_last_char (i_last_char),
        .o_wr        (q_wr),
        .o_rec       (q_wdata)
    );

    // record queue between parser and converter
    itum_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_rdata (q_rdata)
    );

    // conversion pipeline and result register
    itum_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_rec          (q_rdata),
        .o_rd           (q_rd),
        .o_valid        (b_valid),
        .i_pop          (pop),
        .o_unix_millis  (o_unix_millis),
        .o_parse_status (o_parse_status)
    );

endmodule
